>>> sv/vtp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_pkg: shared types and constants of the pseudocolour mapper
// Mapping-mode codes, colormap kinds, divisor codes and the linear-term type.
// ----------------------------------------------------------------------------
package vtp_pkg;

  localparam int RANGE_BITS = 16;
  localparam int CHANNELS   = 4;
  localparam int BYTE_BITS  = 8;

  localparam logic MODE_GRADIENT   = 1'b0;
  localparam logic MODE_PREDEFINED = 1'b1;

  localparam logic [4:0] KIND_JET    = 5'd0;
  localparam logic [4:0] KIND_HEAT   = 5'd1;
  localparam logic [4:0] KIND_HSV    = 5'd2;
  localparam logic [4:0] KIND_HOT    = 5'd3;
  localparam logic [4:0] KIND_COOL   = 5'd4;
  localparam logic [4:0] KIND_SPRING = 5'd5;
  localparam logic [4:0] KIND_SUMMER = 5'd6;
  localparam logic [4:0] KIND_AUTUMN = 5'd7;
  localparam logic [4:0] KIND_WINTER = 5'd8;
  localparam logic [4:0] KIND_GRAY   = 5'd9;
  localparam logic [4:0] KIND_BONE   = 5'd10;
  localparam logic [4:0] KIND_COPPER = 5'd11;
  localparam logic [4:0] KIND_PINK   = 5'd12;
  localparam logic [4:0] KIND_LINES  = 5'd13;
  localparam logic [4:0] KIND_GKR    = 5'd14;
  localparam logic [4:0] KIND_GWR    = 5'd15;
  localparam logic [4:0] KIND_BKR    = 5'd16;
  localparam logic [4:0] KIND_BWR    = 5'd17;
  localparam logic [4:0] KIND_BKG    = 5'd18;
  localparam logic [4:0] KIND_BWG    = 5'd19;

  // denominator d of a term (a*x + b) / d
  typedef enum logic [2:0] {
    DIV_1, DIV_2, DIV_3, DIV_4, DIV_5, DIV_8, DIV_9, DIV_24
  } div_e;

  typedef struct packed {
    logic       mapping_mode;
    logic [4:0] colormap_kind;
    logic [31:0] gradient_first;
    logic [31:0] gradient_last;
  } cfg_t;

  typedef struct packed {
    logic signed [5:0] a;
    logic signed [4:0] b;
    div_e              dv;
    logic              use_f;
  } term_t;

  // x below a breakpoint: eighths, fifths and the half
  typedef struct packed {
    logic e1, e3, e5, e6, e7;
    logic f2, f4;
    logic h1;
  } band_t;

  // lines colormap, channel values in quarters
  localparam logic [2:0] LINES_Q [7][3] = '{
    '{3'd0, 3'd0, 3'd4}, '{3'd0, 3'd2, 3'd0}, '{3'd4, 3'd0, 3'd0},
    '{3'd0, 3'd3, 3'd3}, '{3'd3, 3'd0, 3'd3}, '{3'd3, 3'd3, 3'd0},
    '{3'd1, 3'd1, 3'd1}
  };

  function automatic logic [5:0] div_value(div_e d);
    logic [5:0] v;
    case (d)
      DIV_1:   v = 6'd1;
      DIV_2:   v = 6'd2;
      DIV_3:   v = 6'd3;
      DIV_4:   v = 6'd4;
      DIV_5:   v = 6'd5;
      DIV_8:   v = 6'd8;
      DIV_9:   v = 6'd9;
      DIV_24:  v = 6'd24;
      default: v = 6'd1;
    endcase
    return v;
  endfunction

  function automatic term_t term(int a, int b, div_e d, logic uf);
    term_t t;
    t.a     = 6'(a);
    t.b     = 5'(b);
    t.dv    = d;
    t.use_f = uf;
    return t;
  endfunction

endpackage

`default_nettype wire

>>> sv/vtp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_div: pipelined restoring divider
// Produces floor(dividend * 2^FRAC_BITS / divisor), dividend <= divisor,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module vtp_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  en_i,
  input  wire                                  valid_i,
  input  wire  [vtp_pkg::RANGE_BITS-1:0]        dividend_i,
  input  wire  [vtp_pkg::RANGE_BITS-1:0]        divisor_i,
  output logic                                 valid_o,
  output logic [FRAC_BITS:0]                   quotient_o
);

  localparam int NSTEP = FRAC_BITS + 1;
  localparam int RW    = vtp_pkg::RANGE_BITS;

  logic [NSTEP-1:0] vld_q;
  logic [RW-1:0]    rem_q [NSTEP];
  logic [RW-1:0]    dsr_q [NSTEP];
  logic [FRAC_BITS:0] quo_q [NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic [RW:0]        trial;
    logic [RW-1:0]      dsr;
    logic [FRAC_BITS:0] quo_prev;
    logic               vin;
    logic               qbit;
    logic [RW:0]        diff;
    logic [RW-1:0]      rem_d;

    always_comb begin
      if (i == 0) begin
        trial    = {1'b0, dividend_i};
        dsr      = divisor_i;
        quo_prev = '0;
        vin      = valid_i;
      end else begin
        trial    = {rem_q[(i == 0) ? 0 : i-1], 1'b0};
        dsr      = dsr_q[(i == 0) ? 0 : i-1];
        quo_prev = quo_q[(i == 0) ? 0 : i-1];
        vin      = vld_q[(i == 0) ? 0 : i-1];
      end
      qbit  = (trial >= {1'b0, dsr});
      diff  = trial - {1'b0, dsr};
      rem_d = qbit ? diff[RW-1:0] : trial[RW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d;
        dsr_q[i] <= dsr;
        quo_q[i] <= {quo_prev[FRAC_BITS-1:0], qbit};
      end
    end
  end

  assign valid_o    = vld_q[NSTEP-1];
  assign quotient_o = quo_q[NSTEP-1];

endmodule

`default_nettype wire

>>> sv/vtp_colormap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_colormap: fraction to RGBA colour
// Five stages: banding, term select, numerator, reciprocal divide, byte scale.
// ----------------------------------------------------------------------------
module vtp_colormap #(
  parameter int FRAC_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  wire                  valid_i,
  input  wire  [FRAC_BITS:0]   x_i,
  input  vtp_pkg::cfg_t        cfg_i,
  output logic                 valid_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic [7:0]           alpha_o
);

  localparam int F  = FRAC_BITS;
  localparam int XW = F + 1;
  localparam int NU = F + 8;        // numerator width
  localparam int S  = NU + 6;       // reciprocal shift
  localparam int MW = S;            // reciprocal width
  localparam int CW = F + 6;        // channel value width
  localparam int NC = vtp_pkg::CHANNELS;

  localparam logic [MW-1:0] M_2  = MW'(64'd1 << (S - 1));
  localparam logic [MW-1:0] M_4  = MW'(64'd1 << (S - 2));
  localparam logic [MW-1:0] M_6  = MW'(((64'd1 << S) + 64'd5) / 64'd6);
  localparam logic [MW-1:0] M_8  = MW'(64'd1 << (S - 3));
  localparam logic [MW-1:0] M_10 = MW'(((64'd1 << S) + 64'd9) / 64'd10);
  localparam logic [MW-1:0] M_16 = MW'(64'd1 << (S - 4));
  localparam logic [MW-1:0] M_18 = MW'(((64'd1 << S) + 64'd17) / 64'd18);
  localparam logic [MW-1:0] M_48 = MW'(((64'd1 << S) + 64'd47) / 64'd48);

  localparam vtp_pkg::term_t T_ZERO = vtp_pkg::term(0, 0, vtp_pkg::DIV_1, 1'b0);
  localparam vtp_pkg::term_t T_ONE  = vtp_pkg::term(0, 1, vtp_pkg::DIV_1, 1'b0);
  localparam vtp_pkg::term_t T_X    = vtp_pkg::term(1, 0, vtp_pkg::DIV_1, 1'b0);
  localparam vtp_pkg::term_t T_NX   = vtp_pkg::term(-1, 1, vtp_pkg::DIV_1, 1'b0);
  localparam vtp_pkg::term_t T_F    = vtp_pkg::term(1, 0, vtp_pkg::DIV_1, 1'b1);
  localparam vtp_pkg::term_t T_NF   = vtp_pkg::term(-1, 1, vtp_pkg::DIV_1, 1'b1);
  localparam vtp_pkg::term_t T_UP   = vtp_pkg::term(2, 0, vtp_pkg::DIV_1, 1'b0);
  localparam vtp_pkg::term_t T_DN   = vtp_pkg::term(-2, 2, vtp_pkg::DIV_1, 1'b0);
  localparam vtp_pkg::term_t T_UP2  = vtp_pkg::term(2, -1, vtp_pkg::DIV_1, 1'b0);
  localparam vtp_pkg::term_t T_DN2  = vtp_pkg::term(-2, 1, vtp_pkg::DIV_1, 1'b0);

  function automatic logic [MW-1:0] recip(vtp_pkg::div_e d);
    logic [MW-1:0] m;
    case (d)
      vtp_pkg::DIV_1:  m = M_2;
      vtp_pkg::DIV_2:  m = M_4;
      vtp_pkg::DIV_3:  m = M_6;
      vtp_pkg::DIV_4:  m = M_8;
      vtp_pkg::DIV_5:  m = M_10;
      vtp_pkg::DIV_8:  m = M_16;
      vtp_pkg::DIV_9:  m = M_18;
      vtp_pkg::DIV_24: m = M_48;
      default:         m = M_2;
    endcase
    return m;
  endfunction

  // ---- stage 1: bands, hsv and lines segment ----
  logic [F+3:0]  e8, x5;
  logic [F-1:0]  xh;
  logic [F+2:0]  y6, y7;
  vtp_pkg::band_t band_d, band_q;
  logic [2:0]    i6_d, i6_q, i7_d, i7_q;
  logic [F-1:0]  f_q;
  logic [XW-1:0] x1_q;
  logic          v1_q;

  always_comb begin
    e8 = {x_i, 3'b000};
    x5 = ({3'b000, x_i} << 2) + {3'b000, x_i};
    band_d.e1 = e8 < ((F+4)'(1) << F);
    band_d.e3 = e8 < ((F+4)'(3) << F);
    band_d.e5 = e8 < ((F+4)'(5) << F);
    band_d.e6 = e8 < ((F+4)'(6) << F);
    band_d.e7 = e8 < ((F+4)'(7) << F);
    band_d.f2 = x5 < ((F+4)'(2) << F);
    band_d.f4 = x5 < ((F+4)'(4) << F);
    band_d.h1 = ({x_i, 1'b0} < ((F+2)'(1) << F));
    // hsv and lines wrap the top of the range back to zero
    xh   = x_i[F] ? '0 : x_i[F-1:0];
    y6   = ({3'b000, xh} << 2) + ({3'b000, xh} << 1);
    y7   = ({3'b000, xh} << 3) - {3'b000, xh};
    i6_d = y6[F+2:F];
    i7_d = (y7[F+2:F] > 3'd6) ? 3'd6 : y7[F+2:F];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      band_q <= band_d;
      i6_q   <= i6_d;
      i7_q   <= i7_d;
      f_q    <= y6[F-1:0];
      x1_q   <= x_i;
    end
  end

  // ---- stage 2: term select ----
  vtp_pkg::term_t t_d [NC];
  vtp_pkg::term_t t_q [NC];
  logic [XW-1:0]  op_q [NC];
  logic [XW-1:0]  x2_q;
  logic           v2_q;

  always_comb begin
    for (int k = 0; k < NC; k++) t_d[k] = T_ONE;
    case (cfg_i.colormap_kind)
      vtp_pkg::KIND_JET: begin
        if (band_q.e3) t_d[0] = T_ZERO;
        else if (band_q.e5) t_d[0] = vtp_pkg::term(8, -3, vtp_pkg::DIV_2, 1'b0);
        else if (band_q.e7) t_d[0] = T_ONE;
        else t_d[0] = vtp_pkg::term(-8, 9, vtp_pkg::DIV_2, 1'b0);
        if (band_q.e1) t_d[1] = T_ZERO;
        else if (band_q.e3) t_d[1] = vtp_pkg::term(8, -1, vtp_pkg::DIV_2, 1'b0);
        else if (band_q.e5) t_d[1] = T_ONE;
        else if (band_q.e7) t_d[1] = vtp_pkg::term(-8, 7, vtp_pkg::DIV_2, 1'b0);
        else t_d[1] = T_ZERO;
        if (band_q.e1) t_d[2] = vtp_pkg::term(8, 1, vtp_pkg::DIV_2, 1'b0);
        else if (band_q.e3) t_d[2] = T_ONE;
        else if (band_q.e5) t_d[2] = vtp_pkg::term(-8, 5, vtp_pkg::DIV_2, 1'b0);
        else t_d[2] = T_ZERO;
      end
      vtp_pkg::KIND_HEAT: begin
        t_d[1] = T_ZERO; t_d[2] = T_ZERO; t_d[3] = T_X;
      end
      vtp_pkg::KIND_HSV: begin
        case (i6_q)
          3'd0: begin t_d[0] = T_ONE; t_d[1] = T_F; t_d[2] = T_ZERO; end
          3'd1: begin t_d[0] = T_NF; t_d[1] = T_ONE; t_d[2] = T_ZERO; end
          3'd2: begin t_d[0] = T_ZERO; t_d[1] = T_ONE; t_d[2] = T_F; end
          3'd3: begin t_d[0] = T_ZERO; t_d[1] = T_NF; t_d[2] = T_ONE; end
          3'd4: begin t_d[0] = T_F; t_d[1] = T_ZERO; t_d[2] = T_ONE; end
          default: begin t_d[0] = T_ONE; t_d[1] = T_ZERO; t_d[2] = T_NF; end
        endcase
      end
      vtp_pkg::KIND_HOT: begin
        t_d[0] = band_q.f2 ? vtp_pkg::term(5, 0, vtp_pkg::DIV_2, 1'b0) : T_ONE;
        if (band_q.f2) t_d[1] = T_ZERO;
        else if (band_q.f4) t_d[1] = vtp_pkg::term(5, -2, vtp_pkg::DIV_2, 1'b0);
        else t_d[1] = T_ONE;
        t_d[2] = band_q.f4 ? T_ZERO : vtp_pkg::term(5, -4, vtp_pkg::DIV_1, 1'b0);
      end
      vtp_pkg::KIND_COOL: begin
        t_d[0] = T_X; t_d[1] = T_NX; t_d[2] = T_ONE;
      end
      vtp_pkg::KIND_SPRING: begin
        t_d[0] = T_ONE; t_d[1] = T_X; t_d[2] = T_NX;
      end
      vtp_pkg::KIND_SUMMER: begin
        t_d[0] = T_X;
        t_d[1] = vtp_pkg::term(1, 1, vtp_pkg::DIV_2, 1'b0);
        t_d[2] = vtp_pkg::term(0, 2, vtp_pkg::DIV_5, 1'b0);
      end
      vtp_pkg::KIND_AUTUMN: begin
        t_d[0] = T_ONE; t_d[1] = T_X; t_d[2] = T_ZERO;
      end
      vtp_pkg::KIND_WINTER: begin
        t_d[0] = T_ZERO; t_d[1] = T_X;
        t_d[2] = vtp_pkg::term(-1, 2, vtp_pkg::DIV_2, 1'b0);
      end
      vtp_pkg::KIND_GRAY: begin
        t_d[0] = T_X; t_d[1] = T_X; t_d[2] = T_X;
      end
      vtp_pkg::KIND_BONE: begin
        t_d[0] = band_q.e6 ? vtp_pkg::term(7, 0, vtp_pkg::DIV_8, 1'b0)
                           : vtp_pkg::term(11, -3, vtp_pkg::DIV_8, 1'b0);
        if (band_q.e3) t_d[1] = vtp_pkg::term(7, 0, vtp_pkg::DIV_8, 1'b0);
        else if (band_q.e6) t_d[1] = vtp_pkg::term(29, -3, vtp_pkg::DIV_24, 1'b0);
        else t_d[1] = vtp_pkg::term(7, 1, vtp_pkg::DIV_8, 1'b0);
        t_d[2] = band_q.e3 ? vtp_pkg::term(29, 0, vtp_pkg::DIV_24, 1'b0)
                           : vtp_pkg::term(7, 1, vtp_pkg::DIV_8, 1'b0);
      end
      vtp_pkg::KIND_COPPER: begin
        t_d[0] = band_q.f4 ? vtp_pkg::term(5, 0, vtp_pkg::DIV_4, 1'b0) : T_ONE;
        t_d[1] = vtp_pkg::term(4, 0, vtp_pkg::DIV_5, 1'b0);
        t_d[2] = vtp_pkg::term(1, 0, vtp_pkg::DIV_2, 1'b0);
      end
      vtp_pkg::KIND_PINK: begin
        t_d[0] = band_q.e3 ? vtp_pkg::term(14, 0, vtp_pkg::DIV_9, 1'b0)
                           : vtp_pkg::term(2, 1, vtp_pkg::DIV_3, 1'b0);
        if (band_q.e3) t_d[1] = vtp_pkg::term(2, 0, vtp_pkg::DIV_3, 1'b0);
        else if (band_q.e6) t_d[1] = vtp_pkg::term(14, -3, vtp_pkg::DIV_9, 1'b0);
        else t_d[1] = vtp_pkg::term(2, 1, vtp_pkg::DIV_3, 1'b0);
        t_d[2] = band_q.e6 ? vtp_pkg::term(2, 0, vtp_pkg::DIV_3, 1'b0)
                           : vtp_pkg::term(2, -1, vtp_pkg::DIV_1, 1'b0);
      end
      vtp_pkg::KIND_LINES: begin
        for (int k = 0; k < 3; k++) begin
          t_d[k] = vtp_pkg::term(0, int'(vtp_pkg::LINES_Q[i7_q][k]),
                                 vtp_pkg::DIV_4, 1'b0);
        end
      end
      vtp_pkg::KIND_GKR: begin
        t_d[0] = band_q.h1 ? T_ZERO : T_UP2;
        t_d[1] = band_q.h1 ? T_DN2 : T_ZERO;
        t_d[2] = T_ZERO;
      end
      vtp_pkg::KIND_GWR: begin
        t_d[0] = band_q.h1 ? T_UP : T_ONE;
        t_d[1] = band_q.h1 ? T_ONE : T_DN;
        t_d[2] = band_q.h1 ? T_UP : T_DN;
      end
      vtp_pkg::KIND_BKR: begin
        t_d[0] = band_q.h1 ? T_ZERO : T_UP2;
        t_d[1] = T_ZERO;
        t_d[2] = band_q.h1 ? T_DN2 : T_ZERO;
      end
      vtp_pkg::KIND_BWR: begin
        t_d[0] = band_q.h1 ? T_UP : T_ONE;
        t_d[1] = band_q.h1 ? T_UP : T_DN;
        t_d[2] = band_q.h1 ? T_ONE : T_DN;
      end
      vtp_pkg::KIND_BKG: begin
        t_d[0] = T_ZERO;
        t_d[1] = band_q.h1 ? T_ZERO : T_UP2;
        t_d[2] = band_q.h1 ? T_DN2 : T_ZERO;
      end
      vtp_pkg::KIND_BWG: begin
        t_d[0] = band_q.h1 ? T_UP : T_DN;
        t_d[1] = band_q.h1 ? T_UP : T_ONE;
        t_d[2] = band_q.h1 ? T_ONE : T_DN;
      end
      default: begin
        for (int k = 0; k < NC; k++) t_d[k] = T_ONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NC; k++) begin
        t_q[k]  <= t_d[k];
        op_q[k] <= t_d[k].use_f ? {1'b0, f_q} : x1_q;
      end
      x2_q <= x1_q;
    end
  end

  // ---- stage 3: numerator 2*(a*op + b) + d, gradient product ----
  logic signed [F+9:0]  num_s [NC];
  logic [NU-1:0]        num_q [NC];
  logic [MW-1:0]        m_q   [NC];
  logic signed [F+10:0] gprod_d [NC];
  logic signed [F+10:0] gprod_q [NC];
  logic signed [8:0]    gdiff [NC];
  logic                 v3_q;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      num_s[k] = ((F+10)'(t_q[k].a * $signed({1'b0, op_q[k]}))
                 + ((F+10)'(t_q[k].b) <<< F)) <<< 1;
      num_s[k] = num_s[k] + (F+10)'(vtp_pkg::div_value(t_q[k].dv));
      gdiff[k] = $signed({1'b0, cfg_i.gradient_last[31-8*k -: 8]})
               - $signed({1'b0, cfg_i.gradient_first[31-8*k -: 8]});
      gprod_d[k] = (F+11)'($signed({1'b0, x2_q}) * gdiff[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NC; k++) begin
        num_q[k]   <= num_s[k][NU-1:0];
        m_q[k]     <= recip(t_q[k].dv);
        gprod_q[k] <= gprod_d[k];
      end
    end
  end

  // ---- stage 4: divide by 2d through the reciprocal, gradient add ----
  logic [NU+MW-1:0]    full [NC];
  logic [CW-1:0]       c_q  [NC];
  logic signed [F+10:0] gr  [NC];
  logic signed [11:0]  gv  [NC];
  logic [7:0]          gb_q [NC];
  logic                v4_q;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      full[k] = (NU+MW)'(num_q[k]) * (NU+MW)'(m_q[k]);
      gr[k]   = (gprod_q[k] + ((F+11)'(1) <<< (F - 1))) >>> F;
      gv[k]   = 12'(gr[k]) + 12'($signed({1'b0, cfg_i.gradient_first[31-8*k -: 8]}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NC; k++) begin
        c_q[k] <= full[k][S +: CW];
        if (gv[k] < 0) gb_q[k] <= 8'd0;
        else if (gv[k] > 12'sd255) gb_q[k] <= 8'd255;
        else gb_q[k] <= gv[k][7:0];
      end
    end
  end

  // ---- stage 5: scale to a byte, choose mode ----
  logic [CW+8:0] sc [NC];
  logic [CW+8:0] bv [NC];
  logic [7:0]    out_q [NC];
  logic          v5_q;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      sc[k] = (CW+9)'(c_q[k]) * (CW+9)'(255) + ((CW+9)'(1) << (F - 1));
      bv[k] = sc[k] >> F;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NC; k++) begin
        if (cfg_i.mapping_mode == vtp_pkg::MODE_GRADIENT) out_q[k] <= gb_q[k];
        else if (bv[k] > (CW+9)'(255)) out_q[k] <= 8'd255;
        else out_q[k] <= bv[k][7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end

  assign valid_o = v5_q;
  assign red_o   = out_q[0];
  assign green_o = out_q[1];
  assign blue_o  = out_q[2];
  assign alpha_o = out_q[3];

endmodule

`default_nettype wire

>>> sv/value_to_pseudocolor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// value_to_pseudocolor: signed sample to RGBA pseudocolour
// Clip and scale a sample into a fraction, then colour it by gradient or
// by one of twenty predefined colormaps.
// ----------------------------------------------------------------------------
// One word in, one RGBA word out, one word per clock while the output side
// does not stall. The pipe is one clip stage, one restoring-divider stage per
// quotient bit (FRACTION_BITS + 1 of them) and five colormap stages, the last
// being the output register. The whole pipe advances whenever the output
// register is empty or being taken, so a stall on the output side holds every
// word in place. Write the registers over APB only while no word is in flight.
module value_to_pseudocolor #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // slave side
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,   // sample
  // master side
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [31:0]                           m_axis_tdata,   // red, green, blue, alpha
  // configuration
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [4:0]                            paddr,
  input  wire  [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int RW = vtp_pkg::RANGE_BITS;
  localparam int SW = ((SAMPLE_BITS > RW) ? SAMPLE_BITS : RW) + 1;

  localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd1;
  localparam logic [2:0] REG_MODE       = 3'd2;
  localparam logic [2:0] REG_KIND       = 3'd3;
  localparam logic [2:0] REG_GRAD_FIRST = 3'd4;
  localparam logic [2:0] REG_GRAD_LAST  = 3'd5;

  // ---- configuration registers ----
  logic [RW-1:0] range_low_q, range_high_q;
  vtp_pkg::cfg_t cfg_q;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q          <= '0;
      range_high_q         <= RW'(255);
      cfg_q.mapping_mode   <= vtp_pkg::MODE_PREDEFINED;
      cfg_q.colormap_kind  <= vtp_pkg::KIND_JET;
      cfg_q.gradient_first <= 32'h0000_0000;
      cfg_q.gradient_last  <= 32'hFFFF_FFFF;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_RANGE_LOW:  range_low_q          <= pwdata[RW-1:0];
        REG_RANGE_HIGH: range_high_q         <= pwdata[RW-1:0];
        REG_MODE:       cfg_q.mapping_mode   <= pwdata[0];
        REG_KIND:       cfg_q.colormap_kind  <= pwdata[4:0];
        REG_GRAD_FIRST: cfg_q.gradient_first <= pwdata;
        REG_GRAD_LAST:  cfg_q.gradient_last  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_RANGE_LOW:  prdata = 32'($signed(range_low_q));
      REG_RANGE_HIGH: prdata = 32'($signed(range_high_q));
      REG_MODE:       prdata = {31'd0, cfg_q.mapping_mode};
      REG_KIND:       prdata = {27'd0, cfg_q.colormap_kind};
      REG_GRAD_FIRST: prdata = cfg_q.gradient_first;
      REG_GRAD_LAST:  prdata = cfg_q.gradient_last;
      default:        prdata = 32'd0;
    endcase
  end

  // ---- pipe enable: advance when the output register is free or taken ----
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---- clip stage: clamp into the range, form dividend and divisor ----
  logic signed [SW-1:0] s_ext, lo_ext, hi_ext, s_clip, d_full, w_full;
  logic                 nonempty;
  logic [RW-1:0]        dnd_d, dsr_d, dnd_q, dsr_q;
  logic                 v0_q;

  always_comb begin
    s_ext    = SW'($signed(s_axis_tdata[SAMPLE_BITS-1:0]));
    lo_ext   = SW'($signed(range_low_q));
    hi_ext   = SW'($signed(range_high_q));
    nonempty = hi_ext > lo_ext;
    if (s_ext < lo_ext) s_clip = lo_ext;
    else if (s_ext > hi_ext) s_clip = hi_ext;
    else s_clip = s_ext;
    d_full = s_clip - lo_ext;
    w_full = hi_ext - lo_ext;
    // empty range: force the fraction to zero
    dnd_d = nonempty ? d_full[RW-1:0] : '0;
    dsr_d = nonempty ? w_full[RW-1:0] : RW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dnd_q <= dnd_d;
      dsr_q <= dsr_d;
    end
  end

  // ---- divider: fraction x in Q1.FRACTION_BITS, at most one ----
  logic                   x_valid;
  logic [FRACTION_BITS:0] x;

  vtp_div #(
    .FRAC_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v0_q),
    .dividend_i (dnd_q),
    .divisor_i  (dsr_q),
    .valid_o    (x_valid),
    .quotient_o (x)
  );

  // ---- colour evaluation and output register ----
  logic [7:0] red, green, blue, alpha;

  vtp_colormap #(
    .FRAC_BITS (FRACTION_BITS)
  ) u_colormap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (x_valid),
    .x_i     (x),
    .cfg_i   (cfg_q),
    .valid_o (m_axis_tvalid),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue),
    .alpha_o (alpha)
  );

  assign m_axis_tdata = {alpha, blue, green, red};

  // ---- assertions ----
  a_dividend_le_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q |-> (dnd_q <= dsr_q))
    else $error("dividend exceeds divisor");

  a_fraction_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_valid |-> (x <= ((FRACTION_BITS+1)'(1) << FRACTION_BITS)))
    else $error("fraction above one");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q |-> (dsr_q != '0))
    else $error("zero divisor entered the divider");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for value_to_pseudocolor
// Drive signed samples through the stream input under several register
// settings. Predict each RGBA word from the sample and the register shadow,
// then compare every output word channel by channel in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import vtp_pkg::*;

  localparam longint UNIT      = 64'sd1 << 16;  // 1.0 in the fraction format
  localparam int     LATENCY   = 23;
  localparam int     CYCLE_CAP = 400000;

  // register byte addresses
  localparam logic [4:0] REG_RANGE_LOW  = 5'd0;
  localparam logic [4:0] REG_RANGE_HIGH = 5'd4;
  localparam logic [4:0] REG_MODE       = 5'd8;
  localparam logic [4:0] REG_KIND       = 5'd12;
  localparam logic [4:0] REG_FIRST      = 5'd16;
  localparam logic [4:0] REG_LAST       = 5'd20;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // sample
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // red, green, blue, alpha
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  value_to_pseudocolor dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the configuration registers
  logic signed [15:0] sh_low, sh_high;
  logic               sh_mode;
  logic [4:0]         sh_kind;
  logic [31:0]        sh_first, sh_last;

  logic [31:0] colour_q[$];    // expected RGBA words, oldest first
  int          errors;
  int          cycles;
  int          ready_pct;      // chance per cycle that the receiver takes a word
  bit          bursty;         // sender idles between bursts when set
  int          burst_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Colour prediction
  // ---------------------------------------------------------------------------
  function automatic longint floor_div(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // (a*x + b) / d, rounded to nearest with ties upward
  function automatic longint ramp(longint x, longint a, longint b, longint d);
    return floor_div(2 * (a * x + b * UNIT) + d, 2 * d);
  endfunction

  function automatic logic [7:0] to_byte(longint c);
    longint v;
    v = floor_div(c * 255 + UNIT / 2, UNIT);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // channel levels of a predefined map, one in the fraction format
  function automatic void map_levels(longint x, output longint c[4]);
    longint e, hf, y, seg, f;
    int     q[3];
    e  = x * 8;
    hf = x * 2;
    c  = '{UNIT, UNIT, UNIT, UNIT};
    case (sh_kind)
      KIND_JET: begin
        if (e < 3 * UNIT)      c[0] = 0;
        else if (e < 5 * UNIT) c[0] = ramp(x, 8, -3, 2);
        else if (e < 7 * UNIT) c[0] = UNIT;
        else                   c[0] = ramp(x, -8, 9, 2);
        if (e < 1 * UNIT)      c[1] = 0;
        else if (e < 3 * UNIT) c[1] = ramp(x, 8, -1, 2);
        else if (e < 5 * UNIT) c[1] = UNIT;
        else if (e < 7 * UNIT) c[1] = ramp(x, -8, 7, 2);
        else                   c[1] = 0;
        if (e < 1 * UNIT)      c[2] = ramp(x, 8, 1, 2);
        else if (e < 3 * UNIT) c[2] = UNIT;
        else if (e < 5 * UNIT) c[2] = ramp(x, -8, 5, 2);
        else                   c[2] = 0;
      end
      KIND_HEAT: begin
        c[1] = 0; c[2] = 0; c[3] = x;
      end
      KIND_HSV: begin
        if (x >= UNIT) x = 0;  // the top wraps round to red
        y   = x * 6;
        seg = y >>> 16;
        f   = y - seg * UNIT;
        case (seg)
          0:       begin c[0] = UNIT;     c[1] = f;        c[2] = 0;        end
          1:       begin c[0] = UNIT - f; c[1] = UNIT;     c[2] = 0;        end
          2:       begin c[0] = 0;        c[1] = UNIT;     c[2] = f;        end
          3:       begin c[0] = 0;        c[1] = UNIT - f; c[2] = UNIT;     end
          4:       begin c[0] = f;        c[1] = 0;        c[2] = UNIT;     end
          default: begin c[0] = UNIT;     c[1] = 0;        c[2] = UNIT - f; end
        endcase
      end
      KIND_HOT: begin
        c[0] = (x * 5 < 2 * UNIT) ? ramp(x, 5, 0, 2) : UNIT;
        if (x * 5 < 2 * UNIT)      c[1] = 0;
        else if (x * 5 < 4 * UNIT) c[1] = ramp(x, 5, -2, 2);
        else                       c[1] = UNIT;
        c[2] = (x * 5 < 4 * UNIT) ? 0 : ramp(x, 5, -4, 1);
      end
      KIND_COOL:   begin c[0] = x; c[1] = UNIT - x; c[2] = UNIT; end
      KIND_SPRING: begin c[0] = UNIT; c[1] = x; c[2] = UNIT - x; end
      KIND_SUMMER: begin
        c[0] = x; c[1] = ramp(x, 1, 1, 2); c[2] = ramp(x, 0, 2, 5);
      end
      KIND_AUTUMN: begin c[0] = UNIT; c[1] = x; c[2] = 0; end
      KIND_WINTER: begin c[0] = 0; c[1] = x; c[2] = ramp(x, -1, 2, 2); end
      KIND_GRAY:   begin c[0] = x; c[1] = x; c[2] = x; end
      KIND_BONE: begin
        c[0] = (e < 6 * UNIT) ? ramp(x, 7, 0, 8) : ramp(x, 11, -3, 8);
        if (e < 3 * UNIT)      c[1] = ramp(x, 7, 0, 8);
        else if (e < 6 * UNIT) c[1] = ramp(x, 29, -3, 24);
        else                   c[1] = ramp(x, 7, 1, 8);
        c[2] = (e < 3 * UNIT) ? ramp(x, 29, 0, 24) : ramp(x, 7, 1, 8);
      end
      KIND_COPPER: begin
        c[0] = (x * 5 < 4 * UNIT) ? ramp(x, 5, 0, 4) : UNIT;
        c[1] = ramp(x, 4, 0, 5);
        c[2] = ramp(x, 1, 0, 2);
      end
      KIND_PINK: begin
        c[0] = (e < 3 * UNIT) ? ramp(x, 14, 0, 9) : ramp(x, 2, 1, 3);
        if (e < 3 * UNIT)      c[1] = ramp(x, 2, 0, 3);
        else if (e < 6 * UNIT) c[1] = ramp(x, 14, -3, 9);
        else                   c[1] = ramp(x, 2, 1, 3);
        c[2] = (e < 6 * UNIT) ? ramp(x, 2, 0, 3) : ramp(x, 2, -1, 1);
      end
      KIND_LINES: begin
        if (x >= UNIT) x = 0;  // the top wraps round to the first line
        seg = (x * 7) >>> 16;
        if (seg > 6) seg = 6;
        case (seg)
          0:       q = '{0, 0, 4};
          1:       q = '{0, 2, 0};
          2:       q = '{4, 0, 0};
          3:       q = '{0, 3, 3};
          4:       q = '{3, 0, 3};
          5:       q = '{3, 3, 0};
          default: q = '{1, 1, 1};
        endcase
        for (int k = 0; k < 3; k++) c[k] = q[k] * (UNIT / 4);
      end
      KIND_GKR: begin
        c[0] = (hf < UNIT) ? 0 : ramp(x, 2, -1, 1);
        c[1] = (hf < UNIT) ? ramp(x, -2, 1, 1) : 0;
        c[2] = 0;
      end
      KIND_GWR: begin
        c[0] = (hf < UNIT) ? ramp(x, 2, 0, 1) : UNIT;
        c[1] = (hf < UNIT) ? UNIT : ramp(x, -2, 2, 1);
        c[2] = (hf < UNIT) ? ramp(x, 2, 0, 1) : ramp(x, -2, 2, 1);
      end
      KIND_BKR: begin
        c[0] = (hf < UNIT) ? 0 : ramp(x, 2, -1, 1);
        c[1] = 0;
        c[2] = (hf < UNIT) ? ramp(x, -2, 1, 1) : 0;
      end
      KIND_BWR: begin
        c[0] = (hf < UNIT) ? ramp(x, 2, 0, 1) : UNIT;
        c[1] = (hf < UNIT) ? ramp(x, 2, 0, 1) : ramp(x, -2, 2, 1);
        c[2] = (hf < UNIT) ? UNIT : ramp(x, -2, 2, 1);
      end
      KIND_BKG: begin
        c[0] = 0;
        c[1] = (hf < UNIT) ? 0 : ramp(x, 2, -1, 1);
        c[2] = (hf < UNIT) ? ramp(x, -2, 1, 1) : 0;
      end
      KIND_BWG: begin
        c[0] = (hf < UNIT) ? ramp(x, 2, 0, 1) : ramp(x, -2, 2, 1);
        c[1] = (hf < UNIT) ? ramp(x, 2, 0, 1) : UNIT;
        c[2] = (hf < UNIT) ? UNIT : ramp(x, -2, 2, 1);
      end
      default: ;  // unused kinds stay opaque white
    endcase
  endfunction

  // RGBA word as it leaves the block: red in the lowest byte
  function automatic logic [31:0] predict_colour(logic signed [15:0] sample);
    longint s, x, w, lo, hi, v;
    longint c[4];
    logic [31:0] word;
    s  = sample;
    lo = sh_low;
    hi = sh_high;
    x  = 0;
    if (hi > lo) begin
      w = hi - lo;
      if (s < lo) s = lo;
      if (s > hi) s = hi;
      x = ((s - lo) * UNIT) / w;
    end
    if (sh_mode == MODE_GRADIENT) begin
      for (int k = 0; k < 4; k++) begin
        lo = sh_first[24 - 8 * k +: 8];
        hi = sh_last[24 - 8 * k +: 8];
        v  = lo + floor_div(x * (hi - lo) + UNIT / 2, UNIT);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        word[8 * k +: 8] = 8'(v);
      end
    end else begin
      map_levels(x, c);
      for (int k = 0; k < 4; k++) word[8 * k +: 8] = to_byte(c[k]);
    end
    return word;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall on a pattern of its own and check each word taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (colour_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = colour_q.pop_front();
          for (int k = 0; k < 4; k++)
            if (want[8 * k +: 8] !== m_axis_tdata[8 * k +: 8]) begin
              $display("%0t: channel %0d mismatch, expected %0d, actual %0d",
                       $time, k, want[8 * k +: 8], m_axis_tdata[8 * k +: 8]);
              errors++;
            end
        end
      end
    end
  end

  // hard stop on a hang
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one sample and hold it until taken; drop valid between bursts.
  task automatic send_sample(logic signed [15:0] sample);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    do @(posedge clk_i); while (!s_axis_tready);
    colour_q.insert(colour_q.size(), predict_colour(sample));
    if (bursty) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid and let the pipe empty, so no word is in flight.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (colour_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // Setup phase and access phase, then idle before the next transfer.
  task automatic write_reg(logic [4:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      REG_RANGE_LOW:  sh_low   = value[15:0];
      REG_RANGE_HIGH: sh_high  = value[15:0];
      REG_MODE:       sh_mode  = value[0];
      REG_KIND:       sh_kind  = value[4:0];
      REG_FIRST:      sh_first = value;
      REG_LAST:       sh_last  = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_colours(logic signed [15:0] lo, logic signed [15:0] hi,
                             logic mode, logic [4:0] kind,
                             logic [31:0] first, logic [31:0] last);
    drain();
    write_reg(REG_RANGE_LOW, 32'(lo));
    write_reg(REG_RANGE_HIGH, 32'(hi));
    write_reg(REG_MODE, 32'(mode));
    write_reg(REG_KIND, 32'(kind));
    write_reg(REG_FIRST, first);
    write_reg(REG_LAST, last);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings (jet over 0..255): full-scale samples and band edges.
  task automatic test_reset_jet;
    logic signed [15:0] pts[10] = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd255,
                                    16'sd32, 16'sd96, 16'sd128, 16'sd160,
                                    16'sd224, -16'sd1};
    foreach (pts[i]) send_sample(pts[i]);
  endtask

  // Each map at the bottom, middle and top, an unused kind included; the top
  // checks the wrap to zero on hsv and lines.
  task automatic test_every_map;
    for (int k = 0; k <= 20; k++) begin
      set_colours(-16'sd32768, 16'sd32767, MODE_PREDEFINED,
                  (k == 20) ? 5'd31 : 5'(k), 32'h0, 32'hFFFFFFFF);
      send_sample(-16'sd32768);
      send_sample(16'sd0);
      send_sample(16'sd32767);
    end
  endtask

  // Gradient with opposite extreme colours, then an empty and a reversed range.
  task automatic test_gradient_and_empty;
    set_colours(-16'sd100, 16'sd100, MODE_GRADIENT, KIND_JET, 32'hFF00FF00, 32'h00FF00FF);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(16'sd32767);
    set_colours(16'sd7, 16'sd7, MODE_GRADIENT, KIND_JET, 32'h12345678, 32'h87654321);
    send_sample(16'sd7);
    send_sample(16'sd32767);
    set_colours(16'sd50, -16'sd50, MODE_PREDEFINED, KIND_HEAT, 32'h0, 32'h0);
    send_sample(16'sd0);
    send_sample(-16'sd32768);
  endtask

  // Random settings per phase; samples mostly inside the range.
  task automatic test_random_phases;
    logic signed [15:0] lo, hi, s;
    int span;
    for (int p = 0; p < 18; p++) begin
      case ($urandom_range(0, 5))
        0: begin lo = -16'sd32768; hi = 16'sd32767; end
        1: begin lo = 16'($urandom); hi = lo; end
        2: begin lo = 16'($urandom); hi = 16'($urandom); end
        default: begin
          lo = 16'(int'($urandom_range(0, 65535)) - 32768);
          span = $urandom_range(1, 2000);
          hi = (int'(lo) + span > 32767) ? 16'sd32767 : 16'(int'(lo) + span);
        end
      endcase
      set_colours(lo, hi, ($urandom_range(0, 3) != 0) ? MODE_PREDEFINED : MODE_GRADIENT,
                  ($urandom_range(0, 9) == 0) ? 5'($urandom_range(20, 31))
                                              : 5'($urandom_range(0, 19)),
                  $urandom, $urandom);
      bursty    = (p % 4 != 0);
      ready_pct = (p % 5 == 0) ? 100 : $urandom_range(30, 95);
      for (int i = 0; i < 36; i++) begin
        if ($urandom_range(0, 4) == 0 || hi <= lo)
          s = 16'($urandom);
        else
          s = 16'($urandom_range(0, int'(hi) - int'(lo)) + int'(lo));
        send_sample(s);
        // once, in phase 9, hold off until the pipe is empty
        if (p == 9 && i == 20) drain();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    cycles        = 0;
    ready_pct     = 100;
    bursty        = 1'b0;
    burst_left    = 4;
    sh_low        = 16'sd0;
    sh_high       = 16'sd255;
    sh_mode       = MODE_PREDEFINED;
    sh_kind       = KIND_JET;
    sh_first      = 32'h0;
    sh_last       = 32'hFFFFFFFF;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_jet();
    ready_pct = 70;
    bursty    = 1'b1;
    test_every_map();
    test_gradient_and_empty();
    test_random_phases();

    s_axis_tvalid <= 1'b0;
    ready_pct = 100;
    while (colour_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
